// ===== rtl/dps_pkg.sv =====
// Shared types, constants and arctangent function for the Dirichlet partial sum block.
package dps_pkg;

  localparam int ROTATION_STEPS_DEF = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 56;
  localparam int T_W = 56;
  localparam int LOG_W = 53;
  localparam int WEIGHT_W = 32;
  localparam int ACC_W = 64;
  localparam int PROD_W = 144;
  localparam int FRAC_LSB = 80;

  localparam logic [63:0] INV2PI = 64'h28BE60DB9391054A;
  localparam logic [31:0] INVK = 32'h9B74EDA8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_T = 1'b0,
    REG_ETA_MODE = 1'b1
  } cfg_reg_t;

  // Word moving down the rotation chain
  typedef struct packed {
    logic        valid;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] ang;
  } rot_t;

  // Restoring long division, used only for elaboration-time table values
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-idx in turns, Q0.64
  function automatic logic [63:0] atan_turn(input int idx);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           e;
    rad = '0;
    term = '0;
    if (idx == 0) begin
      return 64'h2000000000000000;
    end
    for (int k = 0; k < 64; k++) begin
      e = idx * (2 * k + 1);
      if (e < 64) begin
        term = udiv64(64'd1 << (64 - e), 64'(2 * k + 1));
        rad = k[0] ? rad - term : rad + term;
      end
    end
    prod = {64'd0, rad} * {64'd0, INV2PI};
    return prod[127:64];
  endfunction

endpackage

// ===== rtl/dps_phase.sv =====
// Serial phase unit: fractional turns of |t| * ln n / (2 pi).
module dps_phase import dps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [T_W-1:0]     tmag,
  input  logic [LOG_W-1:0]   lg,
  output logic               done,
  output logic [63:0]        frac
);

  logic              busy;
  logic              pass;
  logic [5:0]        cnt;
  logic [PROD_W-1:0] mcand;
  logic [T_W-1:0]    mplier;
  logic [PROD_W-1:0] acc;
  logic [T_W-1:0]    tmag_q;
  logic [PROD_W-1:0] acc_next;

  // Add the shifted multiplicand when the current multiplier bit is set
  assign acc_next = acc + (mplier[0] ? mcand : '0);

  // First pass forms ln n * INV2PI, second pass multiplies that by |t|
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pass <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pass <= 1'b0;
        cnt <= 6'(LOG_W - 1);
        mcand <= {{(PROD_W-64){1'b0}}, INV2PI};
        mplier <= {{(T_W-LOG_W){1'b0}}, lg};
        acc <= '0;
        tmag_q <= tmag;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          if (!pass) begin
            pass <= 1'b1;
            cnt <= 6'(T_W - 1);
            mcand <= acc_next;
            mplier <= tmag_q;
            acc <= '0;
          end else begin
            busy <= 1'b0;
            done <= 1'b1;
            frac <= acc_next[PROD_W-1:FRAC_LSB];
          end
        end else begin
          acc <= acc_next;
          mcand <= {mcand[PROD_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[T_W-1:1]};
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/dps_cell.sv =====
// One CORDIC rotation cell with a fixed shift and arctangent step.
module dps_cell import dps_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst,
  input  rot_t cin,
  output rot_t cout
);

  localparam logic [63:0] ATAN = atan_turn(STAGE);

  logic [63:0] dx;
  logic [63:0] dy;

  assign dx = 64'($signed(cin.y) >>> STAGE);
  assign dy = 64'($signed(cin.x) >>> STAGE);

  // Advance the valid mark and rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else begin
      cout.valid <= cin.valid;
    end
    if (cin.ang[63]) begin
      cout.x <= cin.x + dx;
      cout.y <= cin.y - dy;
      cout.ang <= cin.ang + ATAN;
    end else begin
      cout.x <= cin.x - dx;
      cout.y <= cin.y + dy;
      cout.ang <= cin.ang - ATAN;
    end
  end

endmodule

// ===== rtl/dirichlet_partial_sum.sv =====
// Dirichlet partial sum top level: phase unit, CORDIC cell chain, accumulators.
// Each accepted word passes through the serial phase multiplier (a pass over ln n, then one over |t|),
// then the CORDIC cell chain, then the S_SCALE and S_ACC states, before its sum update.
// One item is in flight at a time: a new term is taken only in S_IDLE.
// A finished sum waits in the output register while the next term is taken.
// Synchronous reset clears height_t, eta_mode, accumulators, sign and sticky overflow flags.
module dirichlet_partial_sum import dps_pkg::*; #(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WEIGHT_W-1:0]   term_weight,
  input  logic [LOG_W-1:0]      term_log,
  input  logic                  last_term,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [ACC_W-1:0] sum_real,
  output logic signed [ACC_W-1:0] sum_imag,
  output logic                  overflowed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PHASE = 5'b00010,
    S_ROT   = 5'b00100,
    S_SCALE = 5'b01000,
    S_ACC   = 5'b10000
  } state_t;

  state_t state;
  logic [T_W-1:0] height_t;
  logic           eta_mode;
  logic [ACC_W-1:0] acc_real;
  logic [ACC_W-1:0] acc_imag;
  logic           odd_term;
  logic           sat_seen;
  logic           last_q;
  logic           neg_q;
  logic [63:0]    prod;
  logic [63:0]    add_real;
  logic [63:0]    add_imag;

  logic           in_accept;
  logic [T_W-1:0] tmag;
  logic           ph_done;
  logic [63:0]    ph_frac;
  logic [63:0]    theta;
  logic [63:0]    x0;
  logic           big;
  rot_t           chain [ROTATION_STEPS+1];
  logic [63:0]    xq;
  logic [63:0]    yq;
  logic           flip;
  logic [63:0]    sum_r;
  logic [63:0]    sum_i;
  logic           ovf_r;
  logic           ovf_i;
  logic           acc_go;
  logic           emit;

  assign in_ready = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height_t <= '0;
      eta_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEIGHT_T: height_t <= cfg_data;
        REG_ETA_MODE: eta_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Magnitude of t for the phase multiplier
  assign tmag = height_t[T_W-1] ? (~height_t + T_W'(1)) : height_t;

  dps_phase u_phase (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept),
    .tmag  (tmag),
    .lg    (term_log),
    .done  (ph_done),
    .frac  (ph_frac)
  );

  // Rotation angle is minus the phase; fold beyond a quarter turn
  assign theta = neg_q ? ph_frac : (64'd0 - ph_frac);
  assign big = theta[63] ? (theta < 64'hC000000000000000) : (theta >= 64'h4000000000000000);
  assign x0 = {2'b00, prod[63:2]};

  always_comb begin
    chain[0].valid = ph_done && (state == S_PHASE);
    chain[0].y = '0;
    if (big) begin
      chain[0].x = 64'd0 - x0;
      chain[0].ang = theta + 64'h8000000000000000;
    end else begin
      chain[0].x = x0;
      chain[0].ang = theta;
    end
  end

  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
    dps_cell #(.STAGE(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  // Round to Q23.40 and apply the alternating sign
  assign xq = 64'($signed(chain[ROTATION_STEPS].x + 64'h100000) >>> 21);
  assign yq = 64'($signed(chain[ROTATION_STEPS].y + 64'h100000) >>> 21);
  assign flip = eta_mode && odd_term;

  // Saturating accumulation
  assign sum_r = acc_real + add_real;
  assign sum_i = acc_imag + add_imag;
  assign ovf_r = (acc_real[63] == add_real[63]) && (sum_r[63] != acc_real[63]);
  assign ovf_i = (acc_imag[63] == add_imag[63]) && (sum_i[63] != acc_imag[63]);
  assign acc_go = !(last_q && out_valid && !out_ready);
  assign emit = (state == S_ACC) && acc_go && last_q;

  // Latch the term at acceptance, and the signed addend in S_SCALE
  always_ff @(posedge clk) begin
    if (in_accept) begin
      prod <= {32'd0, term_weight} * {32'd0, INVK};
      last_q <= last_term;
      neg_q <= height_t[T_W-1];
    end
    if (state == S_SCALE) begin
      add_real <= flip ? (64'd0 - xq) : xq;
      add_imag <= flip ? (64'd0 - yq) : yq;
    end
  end

  // Sequence one term, accumulate, emit on the last term
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc_real <= '0;
      acc_imag <= '0;
      odd_term <= 1'b0;
      sat_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Hold the result word until it is taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) state <= S_PHASE;
        end
        S_PHASE: begin
          if (ph_done) state <= S_ROT;
        end
        S_ROT: begin
          if (chain[ROTATION_STEPS].valid) state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (acc_go) begin
            state <= S_IDLE;
            if (last_q) begin
              sum_real <= ovf_r ? (acc_real[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                                : sum_r;
              sum_imag <= ovf_i ? (acc_imag[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                                : sum_i;
              overflowed <= sat_seen || ovf_r || ovf_i;
              acc_real <= '0;
              acc_imag <= '0;
              odd_term <= 1'b0;
              sat_seen <= 1'b0;
            end else begin
              acc_real <= ovf_r ? (acc_real[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                                : sum_r;
              acc_imag <= ovf_i ? (acc_imag[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                                : sum_i;
              odd_term <= ~odd_term;
              sat_seen <= sat_seen || ovf_r || ovf_i;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Dirichlet partial sum block.
`timescale 1ns / 1ps

module tb_top;
  import dps_pkg::*;

  localparam int STEPS = ROTATION_STEPS_DEF;
  localparam int SETTLE = 300;

  typedef struct {
    logic [31:0] weight;
    logic [52:0] log_n;
    logic        last;
  } term_t;

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
    logic        ovf;
  } sum_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [WEIGHT_W-1:0] term_weight;
  logic [LOG_W-1:0] term_log;
  logic last_term;
  logic out_valid;
  logic out_ready;
  logic signed [ACC_W-1:0] sum_real;
  logic signed [ACC_W-1:0] sum_imag;
  logic overflowed;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dirichlet_partial_sum dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .term_weight(term_weight), .term_log(term_log), .last_term(last_term),
    .out_valid(out_valid), .out_ready(out_ready),
    .sum_real(sum_real), .sum_imag(sum_imag), .overflowed(overflowed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  term_t pending_terms[$];
  sum_t  expected_sums[$];
  int    err_count = 0;
  int    sums_seen = 0;

  // Shadow copy of registers and accumulators
  logic [55:0] shadow_height;
  logic        shadow_eta;
  logic [63:0] shadow_re;
  logic [63:0] shadow_im;
  logic        shadow_odd;
  logic        shadow_sat;
  logic [63:0] arctan_turns[64];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Build arctan(2^-i) in turns from the alternating series
  function automatic void build_arctan();
    logic [63:0] rad;
    logic [63:0] piece;
    logic [127:0] prod;
    int e;
    arctan_turns[0] = 64'h2000000000000000;
    for (int i = 1; i < 64; i++) begin
      rad = '0;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e < 64) begin
          piece = (64'd1 << (64 - e)) / 64'(2 * k + 1);
          rad = k[0] ? rad - piece : rad + piece;
        end
      end
      prod = {64'd0, rad} * {64'd0, INV2PI};
      arctan_turns[i] = prod[127:64];
    end
  endfunction

  function automatic logic [63:0] sat_accumulate(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      shadow_sat = 1'b1;
      return a[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    end
    return r;
  endfunction

  // Rotate one weighted term and fold it into the running sum
  function automatic void accumulate_term(input term_t tm);
    logic         neg;
    logic [55:0]  tmag;
    logic [108:0] phase;
    logic [172:0] turns;
    logic [63:0]  ang;
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  dx;
    logic [63:0]  dy;
    sum_t         s;
    neg = shadow_height[55];
    tmag = neg ? (56'd0 - shadow_height) : shadow_height;
    phase = {53'd0, tmag} * {56'd0, tm.log_n};
    turns = {64'd0, phase} * {109'd0, INV2PI};
    ang = neg ? turns[143:80] : 64'd0 - turns[143:80];
    x = ({32'd0, tm.weight} * {32'd0, INVK}) >> 2;
    y = '0;
    // fold angles beyond a quarter turn
    if (ang[63] ? (ang < 64'hC000000000000000) : (ang >= 64'h4000000000000000)) begin
      ang = ang + 64'h8000000000000000;
      x = 64'd0 - x;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = $signed(y) >>> i;
      dy = $signed(x) >>> i;
      if (ang[63]) begin
        x = x + dx;
        y = y - dy;
        ang = ang + arctan_turns[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - arctan_turns[i];
      end
    end
    x = $signed(x + 64'h100000) >>> 21;
    y = $signed(y + 64'h100000) >>> 21;
    if (shadow_eta && shadow_odd) begin
      x = 64'd0 - x;
      y = 64'd0 - y;
    end
    shadow_re = sat_accumulate(shadow_re, x);
    shadow_im = sat_accumulate(shadow_im, y);
    shadow_odd = ~shadow_odd;
    if (tm.last) begin
      s.re = shadow_re;
      s.im = shadow_im;
      s.ovf = shadow_sat;
      expected_sums.push_back(s);
      shadow_re = '0;
      shadow_im = '0;
      shadow_odd = 1'b0;
      shadow_sat = 1'b0;
    end
  endfunction

  // Sender: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    term_t nxt;
    term_t took;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        took.weight = term_weight;
        took.log_n = term_log;
        took.last = last_term;
        accumulate_term(took);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_terms.size() > 0) begin
          nxt = pending_terms.pop_front();
          in_valid <= 1'b1;
          term_weight <= nxt.weight;
          term_log <= nxt.log_n;
          last_term <= nxt.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern, stretches of full readiness, one long hold-off
  int stall_phase = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sums_seen++;
        if (expected_sums.size() == 0) begin
          flag_mismatch("sum with nothing expected");
        end else begin
          if (sum_real !== expected_sums[0].re)
            flag_mismatch($sformatf("sum_real %h, want %h", sum_real, expected_sums[0].re));
          if (sum_imag !== expected_sums[0].im)
            flag_mismatch($sformatf("sum_imag %h, want %h", sum_imag, expected_sums[0].im));
          if (overflowed !== expected_sums[0].ovf)
            flag_mismatch($sformatf("overflowed %b, want %b", overflowed,
                                    expected_sums[0].ovf));
          void'(expected_sums.pop_front());
        end
      end
      stall_phase = (stall_phase + 1) % 512;
      if (!hold_done && sums_seen == 30) begin
        hold_done = 1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_phase < 128) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [55:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HEIGHT_T) shadow_height = val;
    else shadow_eta = val[0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_terms.size() != 0 || in_valid || expected_sums.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void push_term(input logic [31:0] w, input logic [52:0] lg,
                                    input logic last);
    term_t tm;
    tm.weight = w;
    tm.log_n = lg;
    tm.last = last;
    pending_terms.push_back(tm);
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [52:0] pick_log();
    case ($urandom_range(0, 5))
      0: return 53'd0;
      1: return {53{1'b1}};
      2: return 53'($urandom_range(0, 65535)) << $urandom_range(0, 36);
      default: return 53'({$urandom, $urandom});
    endcase
  endfunction

  // Queue sums of random length; optionally leave the last one open
  function automatic void queue_sums(input int n_terms, input bit leave_open);
    int len;
    int made;
    made = 0;
    while (made < n_terms) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++)
        push_term(pick_weight(), pick_log(), k == len - 1);
      made += len;
    end
    if (leave_open)
      for (int k = 0; k < 3; k++) push_term(pick_weight(), pick_log(), 1'b0);
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    term_weight = '0;
    term_log = '0;
    last_term = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_HEIGHT_T;
    cfg_data = '0;
    shadow_height = '0;
    shadow_eta = 1'b0;
    shadow_re = '0;
    shadow_im = '0;
    shadow_odd = 1'b0;
    shadow_sat = 1'b0;
    build_arctan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero height, field extremes, weight above one
    push_term(32'd0, 53'd0, 1'b1);
    push_term(32'h80000000, 53'd0, 1'b1);
    push_term(32'hFFFFFFFF, {53{1'b1}}, 1'b0);
    push_term(32'hFFFFFFFF, 53'd1, 1'b1);
    wait_idle();
    write_reg(REG_HEIGHT_T, 56'h7FFFFFFFFFFFFF);
    push_term(32'h80000000, {53{1'b1}}, 1'b1);
    push_term(32'hFFFFFFFF, 53'h1000000000000, 1'b1);
    push_term(32'h55555555, 53'h0AAAAAAAAAAAAA, 1'b0);
    push_term(32'h80000000, 53'd1, 1'b0);
    wait_idle();
    // mode change in the middle of a sum
    write_reg(REG_ETA_MODE, 56'd1);
    push_term(32'h80000000, 53'h0B17217F7D1CF, 1'b0);
    push_term(32'h40000000, 53'h1193EA7AAD030, 1'b1);
    push_term(32'h80000000, 53'd0, 1'b0);
    push_term(32'h80000000, 53'd0, 1'b0);
    push_term(32'h80000000, 53'd0, 1'b1);
    wait_idle();
    write_reg(REG_HEIGHT_T, 56'h80000000000000);
    push_term(32'hFFFFFFFF, {53{1'b1}}, 1'b0);
    push_term(32'h80000000, 53'h1000000000000, 1'b1);
    push_term(32'h00000001, 53'h0000000000001, 1'b1);
    wait_idle();
    write_reg(REG_HEIGHT_T, 56'hFFFFFFFFFFFFFF);
    push_term(32'h80000000, {53{1'b1}}, 1'b1);
    wait_idle();
    write_reg(REG_ETA_MODE, 56'd0);
    push_term(32'h80000000, 53'h1000000000000, 1'b1);
    wait_idle();

    // random phases across heights and modes
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_reg(REG_HEIGHT_T, 56'h7FFFFFFFFFFFFF);
        1: write_reg(REG_HEIGHT_T, 56'h80000000000000);
        2: write_reg(REG_HEIGHT_T, 56'h00000E00000000);
        default: write_reg(REG_HEIGHT_T, 56'({$urandom, $urandom}));
      endcase
      write_reg(REG_ETA_MODE, 56'($urandom_range(0, 1)));
      queue_sums(200, $urandom_range(0, 1));
      wait_idle();
    end

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== dirichlet_partial_sum.f =====
rtl/dps_pkg.sv
rtl/dps_phase.sv
rtl/dps_cell.sv
rtl/dirichlet_partial_sum.sv
bench/tb_top.sv
